// File: rtl/ptob_pkg.sv
// Shared types, constants and helpers for the price-time order book.
// No dependencies.
package ptob_pkg;

    localparam int ID_W       = 10;
    localparam int PRICE_W    = 32;
    localparam int QTY_W      = 32;
    localparam int NCELL      = 64;
    localparam int NID        = 1 << ID_W;
    localparam int FILL_CNT_W = $clog2(NCELL + 1);
    localparam int SETTLE_W   = 4;
    localparam logic [SETTLE_W-1:0] SETTLE_CYC = SETTLE_W'(9);

    localparam logic [2:0] OP_ADD        = 3'd0;
    localparam logic [2:0] OP_ADD_REP    = 3'd1;
    localparam logic [2:0] OP_CANCEL     = 3'd2;
    localparam logic [2:0] OP_CANCEL_REP = 3'd3;
    localparam logic [2:0] OP_MARKET     = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_DUP      = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    localparam int F_KNOWN = 0;
    localparam int F_LIVE  = 1;
    localparam int F_SELL  = 2;

    typedef struct packed {
        logic [2:0]         operation;
        logic               side;
        logic [ID_W-1:0]    ord_id;
        logic [PRICE_W-1:0] price;
        logic [QTY_W-1:0]   quantity;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic               fill_valid;
        logic [ID_W-1:0]    fill_ord_id;
        logic [PRICE_W-1:0] fill_price;
        logic [QTY_W-1:0]   fill_quantity;
        logic               last;
        logic               best_bid_valid;
        logic [PRICE_W-1:0] best_bid_price;
        logic [QTY_W-1:0]   best_bid_total;
        logic               best_ask_valid;
        logic [PRICE_W-1:0] best_ask_price;
        logic [QTY_W-1:0]   best_ask_total;
    } t_out_item;

    typedef enum logic [2:0] {
        C_HOLD,
        C_INS,
        C_REM,
        C_POP,
        C_DEC
    } t_cop;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECIDE,
        S_FILL,
        S_SETTLE
    } t_state;

    typedef struct packed {
        logic               valid;
        logic [ID_W-1:0]    id;
        logic [PRICE_W-1:0] price;
        logic [QTY_W-1:0]   qty;
    } t_ent;

    typedef struct packed {
        t_cop               op;
        logic               ask;
        logic [ID_W-1:0]    id;
        logic [PRICE_W-1:0] price;
        logic [QTY_W-1:0]   qty;
    } t_ccmd;

    typedef struct packed {
        logic beats;
        logic match;
    } t_cflag;

    typedef struct packed {
        logic ld_new;
        logic ld_left;
        logic ld_right;
        logic dec;
    } t_cctl;

    typedef struct packed {
        logic               valid;
        logic               next_valid;
        logic               full;
        logic [ID_W-1:0]    id;
        logic [PRICE_W-1:0] price;
        logic [QTY_W-1:0]   qty;
        logic [QTY_W-1:0]   total;
    } t_head;

    localparam t_ent EMPTY_ENT = '0;

    function automatic logic [QTY_W-1:0] sat_add(input logic [QTY_W-1:0] a,
                                                 input logic [QTY_W-1:0] b);
        logic [QTY_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[QTY_W] ? {QTY_W{1'b1}} : s[QTY_W-1:0];
    endfunction

endpackage

// File: rtl/ptob_cell.sv
// One slot of a sorted book side: holds a resting order and shifts with neighbors.
// Depends on ptob_pkg.
module ptob_cell
    import ptob_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_ccmd  i_cmd,
    input  t_ent   i_left,
    input  t_ent   i_right,
    input  t_cctl  i_ctl,
    output t_ent   o_ent,
    output t_cflag o_flag
);

    t_ent r_ent;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent.valid <= 1'b0;
        end else if (i_ctl.ld_new) begin
            r_ent <= {1'b1, i_cmd.id, i_cmd.price, i_cmd.qty};
        end else if (i_ctl.ld_left) begin
            r_ent <= i_left;
        end else if (i_ctl.ld_right) begin
            r_ent <= i_right;
        end else if (i_ctl.dec) begin
            r_ent.qty <= r_ent.qty - i_cmd.qty;
        end
    end

    always_comb begin
        o_flag.beats = !r_ent.valid ||
                       (i_cmd.ask ? (r_ent.price > i_cmd.price) : (r_ent.price < i_cmd.price));
        o_flag.match = r_ent.valid && (r_ent.id == i_cmd.id);
    end

    assign o_ent = r_ent;

endmodule

// File: rtl/ptob_chain.sv
// One book side: row of cells kept best first, plus a registered tree for the best level total.
// Depends on ptob_pkg and ptob_cell.
module ptob_chain
    import ptob_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_ccmd i_cmd,
    output t_head o_head
);

    t_ent             ent  [NCELL];
    t_cflag           flag [NCELL];
    t_cctl            ctl  [NCELL];
    logic [NCELL-1:0] cond;
    logic [NCELL-1:0] mv;
    logic [NCELL-1:0] pv;
    logic [QTY_W-1:0] r_node [2*NCELL-1];

    for (genvar i = 0; i < NCELL; i++) begin : g_cell
        ptob_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (i_cmd),
            .i_left  ((i == 0) ? EMPTY_ENT : ent[(i == 0) ? 0 : i-1]),
            .i_right ((i == NCELL-1) ? EMPTY_ENT : ent[(i == NCELL-1) ? i : i+1]),
            .i_ctl   (ctl[i]),
            .o_ent   (ent[i]),
            .o_flag  (flag[i])
        );
        assign cond[i] = flag[i].beats;
    end

    always_comb begin
        for (int i = 0; i < NCELL; i++) begin
            mv[i] = flag[i].match;
        end
        if (i_cmd.op == C_POP) begin
            mv = NCELL'(1);
        end
        pv = ~(mv - NCELL'(1));
        for (int i = 0; i < NCELL; i++) begin
            ctl[i] = '0;
            case (i_cmd.op)
                C_INS: begin
                    ctl[i].ld_new  = cond[i] && ((i == 0) ? 1'b1 : !cond[(i == 0) ? 0 : i-1]);
                    ctl[i].ld_left = (i == 0) ? 1'b0 : cond[(i == 0) ? 0 : i-1];
                end
                C_REM, C_POP: ctl[i].ld_right = pv[i];
                C_DEC:        ctl[i].dec = (i == 0);
                default:      ctl[i] = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        for (int n = 0; n < NCELL-1; n++) begin
            r_node[n] <= sat_add(r_node[2*n+1], r_node[2*n+2]);
        end
        for (int k = 0; k < NCELL; k++) begin
            r_node[NCELL-1+k] <= (ent[k].valid && ent[k].price == ent[0].price) ?
                                 ent[k].qty : '0;
        end
    end

    always_comb begin
        o_head.valid      = ent[0].valid;
        o_head.next_valid = ent[1].valid;
        o_head.full       = ent[NCELL-1].valid;
        o_head.id         = ent[0].id;
        o_head.price      = ent[0].price;
        o_head.qty        = ent[0].qty;
        o_head.total      = r_node[0];
    end

endmodule

// File: rtl/price_time_order_book_top.sv
// Top level of the price-time order book: id flag memory, sequencer, bid and ask chains.
// Depends on ptob_pkg and ptob_chain.
//
//  channel | direction | handshake                 | payload
//  input   | in        | i_in_valid / o_in_ready   | i_in_data  (t_in_item)
//  output  | out       | o_out_valid / i_out_ready | o_out_data (t_out_item)
//
// Add, cancel and other ops: accept and decide, then a settle wait for the level-total
// tree, one transaction out. Market order: accept and decide, then per fill one fill
// step plus a settle wait, up to 64 fills.
// The settle time is set by the 7-stage total tree.
// After reset a clearing pass sweeps all 1024 entries of the id flag memory; no input is taken.
// A stalled output holds the sequencer before its next result only.
module price_time_order_book_top
    import ptob_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    t_state r_state, n_state;

    logic [2:0]            r_flags_mem [NID];
    logic [2:0]            r_flags_rd;
    logic                  flg_we;
    logic [ID_W-1:0]       flg_addr;
    logic [2:0]            flg_data;
    logic [ID_W-1:0]       r_clr;

    t_in_item              r_item;
    logic [QTY_W-1:0]      r_want;
    logic [FILL_CNT_W-1:0] r_nfill;
    logic [SETTLE_W-1:0]   r_cnt;
    logic [1:0]            r_status;
    logic                  r_fv;
    logic [ID_W-1:0]       r_fid;
    logic [PRICE_W-1:0]    r_fprice;
    logic [QTY_W-1:0]      r_fqty;
    logic                  r_last;
    t_out_item             r_out;
    logic                  r_out_valid;

    t_ccmd                 cmd [2];
    t_head                 hd  [2];

    logic                  accept;
    logic                  is_add, is_cxl, known, live, mkt_go;
    logic [1:0]            dec_status;
    logic                  tgt, pop, fill_last;
    logic [QTY_W-1:0]      fq, want_next;

    assign accept = i_in_valid && o_in_ready;

    ptob_chain u_bid (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd[0]), .o_head(hd[0]));
    ptob_chain u_ask (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd[1]), .o_head(hd[1]));

    always_ff @(posedge i_clk) begin
        if (flg_we) begin
            r_flags_mem[flg_addr] <= flg_data;
        end
        r_flags_rd <= r_flags_mem[i_in_data.ord_id];
    end

    always_comb begin
        is_add = (r_item.operation == OP_ADD) || (r_item.operation == OP_ADD_REP);
        is_cxl = (r_item.operation == OP_CANCEL) || (r_item.operation == OP_CANCEL_REP);
        known  = r_flags_rd[F_KNOWN];
        live   = r_flags_rd[F_LIVE];
        mkt_go = (r_item.operation == OP_MARKET) && (r_item.quantity != '0) &&
                 hd[!r_item.side].valid;
        if (is_add) begin
            dec_status = known ? ST_DUP :
                         (r_item.quantity == '0) ? ST_OK :
                         hd[r_item.side].full ? ST_FULL : ST_OK;
        end else if (is_cxl) begin
            dec_status = (known && live) ? ST_OK : ST_NOTFOUND;
        end else begin
            dec_status = ST_OK;
        end
        tgt       = !r_item.side;
        pop       = (r_want >= hd[tgt].qty);
        fq        = pop ? hd[tgt].qty : r_want;
        want_next = r_want - fq;
        fill_last = (want_next == '0) || (pop && !hd[tgt].next_valid) ||
                    (r_nfill == FILL_CNT_W'(NCELL-1));
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR:  if (r_clr == ID_W'(NID-1)) n_state = S_IDLE;
            S_IDLE:   if (accept) n_state = S_DECIDE;
            S_DECIDE: n_state = mkt_go ? S_FILL : S_SETTLE;
            S_FILL:   n_state = S_SETTLE;
            S_SETTLE: begin
                if (r_cnt == '0 && !r_out_valid) begin
                    n_state = r_last ? S_IDLE : S_FILL;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        flg_we     = 1'b0;
        flg_addr   = r_item.ord_id;
        flg_data   = '0;
        cmd[0]     = {C_HOLD, 1'b0, r_item.ord_id, r_item.price, r_item.quantity};
        cmd[1]     = {C_HOLD, 1'b1, r_item.ord_id, r_item.price, r_item.quantity};
        case (r_state)
            S_CLEAR: begin
                flg_we   = 1'b1;
                flg_addr = r_clr;
            end
            S_IDLE: o_in_ready = 1'b1;
            S_DECIDE: begin
                if (is_add && !known) begin
                    if (r_item.quantity == '0) begin
                        flg_we   = 1'b1;
                        flg_data = {r_item.side, 1'b0, 1'b1};
                    end else if (!hd[r_item.side].full) begin
                        flg_we   = 1'b1;
                        flg_data = {r_item.side, 1'b1, 1'b1};
                        cmd[r_item.side].op = C_INS;
                    end
                end
                if (is_cxl && known && live) begin
                    flg_we   = 1'b1;
                    flg_data = r_flags_rd & ~(3'b1 << F_LIVE);
                    cmd[r_flags_rd[F_SELL]].op = C_REM;
                end
            end
            S_FILL: begin
                cmd[tgt].op  = pop ? C_POP : C_DEC;
                cmd[tgt].qty = fq;
                if (pop) begin
                    flg_we   = 1'b1;
                    flg_addr = hd[tgt].id;
                    flg_data = {tgt, 1'b0, 1'b1};
                end
            end
            default: o_in_ready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_nfill     <= '0;
        end else begin
            r_state <= n_state;
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: r_clr <= r_clr + ID_W'(1);
                S_IDLE:  if (accept) r_item <= i_in_data;
                S_DECIDE: begin
                    r_status <= dec_status;
                    r_fv     <= 1'b0;
                    r_fid    <= '0;
                    r_fprice <= '0;
                    r_fqty   <= '0;
                    r_last   <= 1'b1;
                    r_want   <= r_item.quantity;
                    r_nfill  <= '0;
                    r_cnt    <= SETTLE_CYC;
                end
                S_FILL: begin
                    r_status <= ST_OK;
                    r_fv     <= 1'b1;
                    r_fid    <= hd[tgt].id;
                    r_fprice <= hd[tgt].price;
                    r_fqty   <= fq;
                    r_last   <= fill_last;
                    r_want   <= want_next;
                    r_nfill  <= r_nfill + FILL_CNT_W'(1);
                    r_cnt    <= SETTLE_CYC;
                end
                S_SETTLE: begin
                    if (r_cnt != '0) begin
                        r_cnt <= r_cnt - SETTLE_W'(1);
                    end else if (!r_out_valid) begin
                        r_out_valid <= 1'b1;
                        r_out <= {r_status, r_fv, r_fid, r_fprice, r_fqty, r_last,
                                  hd[0].valid,
                                  hd[0].valid ? hd[0].price : {PRICE_W{1'b0}},
                                  hd[0].valid ? hd[0].total : {QTY_W{1'b0}},
                                  hd[1].valid,
                                  hd[1].valid ? hd[1].price : {PRICE_W{1'b0}},
                                  hd[1].valid ? hd[1].total : {QTY_W{1'b0}}};
                    end
                end
                default: r_cnt <= '0;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_fill_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.fill_valid) |-> (o_out_data.status == ST_OK))
        else $error("fill carries non-ok status");

    a_fill_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILL) |-> hd[tgt].valid)
        else $error("fill against an empty side");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_nfill <= FILL_CNT_W'(NCELL)))
        else $error("fill count past limit");

    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> (!o_in_ready && flg_we))
        else $error("input taken during flag clear");

endmodule

// File: bench/tb_price_time_order_book_top.sv
// Self-checking testbench for price_time_order_book_top: directed and random order traffic
// with a clocked driver and monitor, a built-in book predictor and randomized flow control.
// Depends on ptob_pkg and the price_time_order_book_top RTL.
`timescale 1ns / 100ps

module tb_price_time_order_book_top;
    import ptob_pkg::*;

    localparam int IDLE_LIMIT = 8000;
    localparam int HOLD_CYCLES = 700;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_data = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_data;

    price_time_order_book_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    t_in_item  pending_orders[$];
    t_out_item expected_reports[$];
    int        errors = 0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    bit        hold_req = 1'b0;
    bit        hold_done = 1'b0;
    int        hold_cnt = 0;
    int        quiet_cycles = 0;

    // book shadow state
    logic [2:0]         book_flags[NID];
    logic [PRICE_W-1:0] book_price[NID];
    logic [QTY_W-1:0]   book_remaining[NID];
    int                 bid_queue[$];
    int                 ask_queue[$];

    // generator bookkeeping
    bit used_ids[NID];
    int added_ids[$];

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic void best_level(input bit ask_side, output logic v,
                                       output logic [PRICE_W-1:0] p,
                                       output logic [QTY_W-1:0] t);
        int q[$];
        logic [QTY_W:0] sum;
        q = ask_side ? ask_queue : bid_queue;
        v = 1'b0; p = '0; t = '0; sum = '0;
        if (q.size() == 0) return;
        v = 1'b1;
        p = book_price[q[0]];
        foreach (q[i]) begin
            if (book_price[q[i]] != p) break;
            sum = sum + book_remaining[q[i]];
            if (sum[QTY_W]) sum = {1'b0, {QTY_W{1'b1}}};
        end
        t = sum[QTY_W-1:0];
    endfunction

    function automatic t_out_item make_report(input logic [1:0] st, input logic fv,
                                              input logic [ID_W-1:0] id,
                                              input logic [PRICE_W-1:0] p,
                                              input logic [QTY_W-1:0] q);
        t_out_item r;
        r = '0;
        r.status = st;
        r.fill_valid = fv;
        r.fill_ord_id = id;
        r.fill_price = p;
        r.fill_quantity = q;
        best_level(1'b0, r.best_bid_valid, r.best_bid_price, r.best_bid_total);
        best_level(1'b1, r.best_ask_valid, r.best_ask_price, r.best_ask_total);
        return r;
    endfunction

    function automatic logic [1:0] book_add(input t_in_item it);
        int q[$];
        int pos;
        logic [PRICE_W-1:0] qp;
        if (book_flags[it.ord_id][F_KNOWN]) return ST_DUP;
        if (it.quantity == '0) begin
            book_flags[it.ord_id] = '0;
            book_flags[it.ord_id][F_KNOWN] = 1'b1;
            book_flags[it.ord_id][F_SELL] = it.side;
            return ST_OK;
        end
        q = it.side ? ask_queue : bid_queue;
        if (q.size() >= NCELL) return ST_FULL;
        pos = q.size();
        foreach (q[i]) begin
            qp = book_price[q[i]];
            if (it.side ? (qp > it.price) : (qp < it.price)) begin
                pos = i;
                break;
            end
        end
        q.insert(pos, int'(it.ord_id));
        if (it.side) ask_queue = q; else bid_queue = q;
        book_flags[it.ord_id] = 3'b011 | {it.side, 2'b00};
        book_price[it.ord_id] = it.price;
        book_remaining[it.ord_id] = it.quantity;
        return ST_OK;
    endfunction

    function automatic logic [1:0] book_cancel(input logic [ID_W-1:0] id);
        int q[$];
        if (!book_flags[id][F_KNOWN] || !book_flags[id][F_LIVE]) return ST_NOTFOUND;
        q = book_flags[id][F_SELL] ? ask_queue : bid_queue;
        foreach (q[i]) begin
            if (q[i] == id) begin
                q.delete(i);
                break;
            end
        end
        if (book_flags[id][F_SELL]) ask_queue = q; else bid_queue = q;
        book_flags[id][F_LIVE] = 1'b0;
        return ST_OK;
    endfunction

    function automatic void predict_reports(input t_in_item it);
        t_out_item rs[$];
        t_out_item r;
        int q[$];
        int rid;
        logic [QTY_W-1:0] want, fq;
        case (it.operation)
            OP_ADD, OP_ADD_REP: begin
                r = make_report(book_add(it), 1'b0, '0, '0, '0);
                rs.insert(rs.size(), r);
            end
            OP_CANCEL, OP_CANCEL_REP: begin
                r = make_report(book_cancel(it.ord_id), 1'b0, '0, '0, '0);
                rs.insert(rs.size(), r);
            end
            OP_MARKET: begin
                want = it.quantity;
                q = it.side ? bid_queue : ask_queue;
                while (want != '0 && q.size() > 0 && rs.size() < NCELL) begin
                    rid = q[0];
                    fq = (want < book_remaining[rid]) ? want : book_remaining[rid];
                    book_remaining[rid] -= fq;
                    want -= fq;
                    if (book_remaining[rid] == '0) begin
                        book_flags[rid][F_LIVE] = 1'b0;
                        q.delete(0);
                    end
                    if (it.side) bid_queue = q; else ask_queue = q;
                    r = make_report(ST_OK, 1'b1, rid[ID_W-1:0], book_price[rid], fq);
                    rs.insert(rs.size(), r);
                end
                if (rs.size() == 0) begin
                    r = make_report(ST_OK, 1'b0, '0, '0, '0);
                    rs.insert(rs.size(), r);
                end
            end
            default: begin
                r = make_report(ST_OK, 1'b0, '0, '0, '0);
                rs.insert(rs.size(), r);
            end
        endcase
        rs[rs.size()-1].last = 1'b1;
        foreach (rs[i]) expected_reports.insert(expected_reports.size(), rs[i]);
    endfunction

    function automatic void check_field(input string name, input logic [63:0] exp_v,
                                        input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            errors++;
            $display("%0t: mismatch on %s: expected %0h, actual %0h", $time, name,
                     exp_v, act_v);
        end
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) predict_reports(i_in_data);
            if (!i_in_valid || o_in_ready) begin
                if (pending_orders.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_in_data <= pending_orders[0];
                    pending_orders.delete(0);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_out_item e;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_reports.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected transaction, actual %0h", $time, o_out_data);
                end else begin
                    e = expected_reports[0];
                    expected_reports.delete(0);
                    check_field("status", e.status, o_out_data.status);
                    check_field("fill_valid", e.fill_valid, o_out_data.fill_valid);
                    check_field("fill_ord_id", e.fill_ord_id, o_out_data.fill_ord_id);
                    check_field("fill_price", e.fill_price, o_out_data.fill_price);
                    check_field("fill_quantity", e.fill_quantity, o_out_data.fill_quantity);
                    check_field("last", e.last, o_out_data.last);
                    check_field("best_bid_valid", e.best_bid_valid, o_out_data.best_bid_valid);
                    check_field("best_bid_price", e.best_bid_price, o_out_data.best_bid_price);
                    check_field("best_bid_total", e.best_bid_total, o_out_data.best_bid_total);
                    check_field("best_ask_valid", e.best_ask_valid, o_out_data.best_ask_valid);
                    check_field("best_ask_price", e.best_ask_price, o_out_data.best_ask_price);
                    check_field("best_ask_total", e.best_ask_total, o_out_data.best_ask_total);
                end
            end
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                hold_cnt = HOLD_CYCLES;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("tb_price_time_order_book_top failed");
            $finish;
        end
    end

    task automatic queue_order(input logic [2:0] op, input logic side,
                               input logic [ID_W-1:0] id, input logic [PRICE_W-1:0] p,
                               input logic [QTY_W-1:0] q);
        t_in_item it;
        it.operation = op;
        it.side = side;
        it.ord_id = id;
        it.price = p;
        it.quantity = q;
        pending_orders.insert(pending_orders.size(), it);
        if (op == OP_ADD || op == OP_ADD_REP) begin
            used_ids[id] = 1'b1;
            added_ids.insert(added_ids.size(), int'(id));
        end
    endtask

    function automatic logic [ID_W-1:0] fresh_id();
        int id;
        do id = $urandom_range(0, NID - 1); while (used_ids[id]);
        return id[ID_W-1:0];
    endfunction

    task automatic queue_random(input int n);
        int r;
        logic [PRICE_W-1:0] p;
        logic [QTY_W-1:0] q;
        repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                p = ($urandom_range(0, 9) == 0) ? $urandom : 1000 + $urandom_range(0, 7);
                case ($urandom_range(0, 9))
                    0: q = '0;
                    1: q = $urandom;
                    default: q = $urandom_range(1, 50);
                endcase
                queue_order($urandom_range(0, 1) ? OP_ADD_REP : OP_ADD,
                            1'($urandom_range(0, 1)), fresh_id(), p, q);
            end else if (r < 65) begin
                queue_order($urandom_range(0, 1) ? OP_CANCEL_REP : OP_CANCEL,
                            1'($urandom_range(0, 1)),
                            ID_W'(($urandom_range(0, 4) == 0 || added_ids.size() == 0) ?
                                  $urandom_range(0, NID - 1) :
                                  added_ids[$urandom_range(0, added_ids.size() - 1)]),
                            $urandom, $urandom);
            end else if (r < 90) begin
                queue_order(OP_MARKET, 1'($urandom_range(0, 1)), ID_W'($urandom), $urandom,
                            ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(1, 150));
            end else if (r < 95 && added_ids.size() > 0) begin
                queue_order($urandom_range(0, 1) ? OP_ADD_REP : OP_ADD,
                            1'($urandom_range(0, 1)),
                            ID_W'(added_ids[$urandom_range(0, added_ids.size() - 1)]),
                            $urandom, $urandom_range(1, 50));
            end else begin
                queue_order(3'($urandom_range(5, 7)), 1'($urandom_range(0, 1)),
                            ID_W'($urandom), $urandom, $urandom);
            end
        end
    endtask

    // fill one side past capacity, then sweep it with one market order
    task automatic queue_fill_side(input logic side);
        repeat (NCELL + 2)
            queue_order(OP_ADD, side, fresh_id(), 500 + $urandom_range(0, 3),
                        $urandom_range(1, 20));
        queue_order(OP_MARKET, ~side, '0, '0, '1);
    endtask

    task automatic wait_drained();
        while (pending_orders.size() > 0 || i_in_valid || expected_reports.size() > 0)
            @(posedge i_clk);
        repeat (15) @(posedge i_clk);
    endtask

    initial begin
        foreach (book_flags[i]) book_flags[i] = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        queue_order(OP_ADD, 1'b0, 10'd0, '0, '1);
        queue_order(OP_ADD_REP, 1'b0, 10'd1023, '0, '1);
        queue_order(OP_ADD, 1'b1, 10'd5, '1, 32'd1);
        queue_order(OP_ADD_REP, 1'b1, 10'd5, 32'd7, 32'd7);
        queue_order(OP_ADD, 1'b1, 10'd6, 32'd9, '0);
        queue_order(OP_CANCEL, 1'b0, 10'd6, '0, '0);
        queue_order(OP_CANCEL_REP, 1'b1, 10'd999, '0, '0);
        queue_order(OP_MARKET, 1'b0, '0, '0, '0);
        queue_order(OP_MARKET, 1'b0, '0, '0, 32'd1);
        queue_order(OP_MARKET, 1'b0, '0, '0, 32'd5);
        queue_order(OP_MARKET, 1'b1, '0, '0, 32'd3);
        queue_order(OP_CANCEL, 1'b1, 10'd0, '0, '0);
        queue_order(OP_CANCEL_REP, 1'b0, 10'd1023, '0, '0);
        queue_order(OP_ADD, 1'b1, 10'd512, 32'h8000_0000, 32'h8000_0000);
        queue_order(OP_MARKET, 1'b0, '1, '1, '1);
        queue_order(3'd5, 1'b0, '0, '0, '0);
        queue_order(3'd6, 1'b1, '1, '1, '1);
        queue_order(3'd7, 1'b0, '0, '0, '0);
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
                default: begin send_idle_pct = 34; recv_stall_pct = 34; end
            endcase
            if (ph == 0) queue_fill_side(1'b0);
            if (ph == 3) queue_fill_side(1'b1);
            if (ph == 2) hold_req = 1'b1;
            queue_random(37);
            wait_drained();
        end

        send_idle_pct = 0;
        recv_stall_pct = 0;
        wait_drained();
        if (errors == 0)
            $display("tb_price_time_order_book_top passed");
        else
            $display("tb_price_time_order_book_top failed");
        $finish;
    end

endmodule

// File: filelist.f
rtl/ptob_pkg.sv
rtl/ptob_cell.sv
rtl/ptob_chain.sv
rtl/price_time_order_book_top.sv
bench/tb_price_time_order_book_top.sv
